/* hw/rtl/spq_pkg.sv */
// Package for the sorted priority queue: default sizes, operation and status codes.
`default_nettype none

package spq_pkg;

  // Default number of cells in the chain and width of the stored ready time.
  localparam int SPQ_DEPTH     = 16;
  localparam int SPQ_KEY_WIDTH = 16;

  // Width of the data fields on the ports.
  localparam int SPQ_FIELD_W = 16;
  localparam int SPQ_FILL_W  = 5;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_POP    = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Operation broadcast to every cell in the chain.
  typedef struct packed {
    logic ins;
    logic pop;
  } spq_op_t;

endpackage : spq_pkg

`default_nettype wire

/* hw/rtl/spq_cell.sv */
// One cell of the sorted chain: holds one entry and picks keep, new, left or right.
`default_nettype none

module spq_cell #(
  parameter int KEY_WIDTH = 16,
  parameter int CNT_W     = 5,
  parameter int IDX       = 0
) (
  input  wire logic                           clk,
  input  wire spq_pkg::spq_op_t               op,
  input  wire logic [CNT_W-1:0]               count,
  input  wire logic [KEY_WIDTH-1:0]           new_time,
  input  wire logic [spq_pkg::SPQ_FIELD_W-1:0] new_id,
  input  wire logic [spq_pkg::SPQ_FIELD_W-1:0] new_pay,
  input  wire logic                           left_ahead,
  input  wire logic [KEY_WIDTH-1:0]           left_time,
  input  wire logic [spq_pkg::SPQ_FIELD_W-1:0] left_id,
  input  wire logic [spq_pkg::SPQ_FIELD_W-1:0] left_pay,
  input  wire logic [KEY_WIDTH-1:0]           right_time,
  input  wire logic [spq_pkg::SPQ_FIELD_W-1:0] right_id,
  input  wire logic [spq_pkg::SPQ_FIELD_W-1:0] right_pay,
  output logic                                ahead,
  output logic [KEY_WIDTH-1:0]                time_q,
  output logic [spq_pkg::SPQ_FIELD_W-1:0]     id_q,
  output logic [spq_pkg::SPQ_FIELD_W-1:0]     pay_q
);
  import spq_pkg::*;

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [KEY_WIDTH-1:0]   time_r, time_nxt;
  logic [SPQ_FIELD_W-1:0] id_r, id_nxt;
  logic [SPQ_FIELD_W-1:0] pay_r, pay_nxt;
  logic                   used;

  // A held entry stays ahead of the new one when its key is smaller or equal.
  assign used  = IDX_C < count;
  assign ahead = used && ((time_r < new_time) || ((time_r == new_time) && (id_r <= new_id)));

  always_comb begin
    time_nxt = time_r;
    id_nxt   = id_r;
    pay_nxt  = pay_r;
    if (op.ins && !ahead) begin
      if (left_ahead) begin
        time_nxt = new_time;
        id_nxt   = new_id;
        pay_nxt  = new_pay;
      end else begin
        time_nxt = left_time;
        id_nxt   = left_id;
        pay_nxt  = left_pay;
      end
    end else if (op.pop) begin
      time_nxt = right_time;
      id_nxt   = right_id;
      pay_nxt  = right_pay;
    end
  end

  always_ff @(posedge clk) begin
    time_r <= time_nxt;
    id_r   <= id_nxt;
    pay_r  <= pay_nxt;
  end

  assign time_q = time_r;
  assign id_q   = id_r;
  assign pay_q  = pay_r;

endmodule : spq_cell

`default_nettype wire

/* hw/rtl/sorted_priority_queue_unit.sv */
// Top level of the sorted priority queue: chain of entry cells, fill count and result register.
`default_nettype none

// Usage
// The input channel (in_vld / in_rdy) carries one command per beat: in_action selects
// insert or pop; in_ready_time, in_entry_id and in_payload describe the entry to insert.
// Entries are kept sorted by ready time, then by id; an entry equal to held ones goes
// behind them, so equal entries leave in arrival order.
// Every command yields exactly one result beat on the output channel (out_vld / out_rdy):
// out_valid with the popped entry, out_status (ok, insert dropped because full, pop on
// empty) and out_fill_level, the number of entries held after the command.
// The result is written into the output register in the cycle after the command is
// accepted. One command is taken per cycle while the receiver keeps up; every cell
// compares the new key against its own entry in parallel and shifts in the same cycle,
// so the single fill count update is the only serial step.
// When the receiver stalls, the result waits in the output register and in_rdy drops
// until it is taken; a result taken in the same cycle lets the next command in at once.
// Reset clears the fill count and out_vld; the cell contents are left as they
// are and only entries below the fill count are ever read.

module sorted_priority_queue_unit #(
  parameter int QUEUE_DEPTH = spq_pkg::SPQ_DEPTH,
  parameter int KEY_WIDTH   = spq_pkg::SPQ_KEY_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_vld,
  output logic                                 in_rdy,
  input  wire logic                            in_action,
  input  wire logic [spq_pkg::SPQ_FIELD_W-1:0] in_ready_time,
  input  wire logic [spq_pkg::SPQ_FIELD_W-1:0] in_entry_id,
  input  wire logic [spq_pkg::SPQ_FIELD_W-1:0] in_payload,
  output logic                                 out_vld,
  input  wire logic                            out_rdy,
  output logic                                 out_valid,
  output logic [spq_pkg::SPQ_FIELD_W-1:0]      out_time,
  output logic [spq_pkg::SPQ_FIELD_W-1:0]      out_id,
  output logic [spq_pkg::SPQ_FIELD_W-1:0]      out_payload,
  output logic [1:0]                           out_status,
  output logic [spq_pkg::SPQ_FILL_W-1:0]       out_fill_level
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  logic                   acc;
  logic                   full;
  logic                   empty;
  spq_op_t                op;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [KEY_WIDTH-1:0]   new_time;
  logic [SPQ_FIELD_W-1:0] head_time;
  logic [SPQ_FILL_W-1:0]  fill_nxt;
  status_t                status_nxt;

  // Cell outputs and the neighbor inputs built from them.
  logic [KEY_WIDTH-1:0]   c_time  [QUEUE_DEPTH];
  logic [SPQ_FIELD_W-1:0] c_id    [QUEUE_DEPTH];
  logic [SPQ_FIELD_W-1:0] c_pay   [QUEUE_DEPTH];
  logic                   c_ahead [QUEUE_DEPTH];
  logic [KEY_WIDTH-1:0]   l_time  [QUEUE_DEPTH];
  logic [SPQ_FIELD_W-1:0] l_id    [QUEUE_DEPTH];
  logic [SPQ_FIELD_W-1:0] l_pay   [QUEUE_DEPTH];
  logic                   l_ahead [QUEUE_DEPTH];
  logic [KEY_WIDTH-1:0]   r_time  [QUEUE_DEPTH];
  logic [SPQ_FIELD_W-1:0] r_id    [QUEUE_DEPTH];
  logic [SPQ_FIELD_W-1:0] r_pay   [QUEUE_DEPTH];

  // Output register.
  logic                   out_vld_r;
  logic                   out_valid_r;
  logic [SPQ_FIELD_W-1:0] out_time_r;
  logic [SPQ_FIELD_W-1:0] out_id_r;
  logic [SPQ_FIELD_W-1:0] out_pay_r;
  status_t                out_status_r;
  logic [SPQ_FILL_W-1:0]  out_fill_r;

  // A new command enters whenever the output register is free or being emptied.
  assign in_rdy = !out_vld_r || out_rdy;
  assign acc    = in_vld && in_rdy;
  assign full   = count_r == DEPTH_C;
  assign empty  = count_r == '0;

  // Rejected commands (insert when full, pop when empty) leave the chain untouched.
  assign op.ins = acc && (in_action == ACT_INSERT) && !full;
  assign op.pop = acc && (in_action == ACT_POP) && !empty;

  always_comb begin
    count_nxt = count_r;
    if (op.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (op.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    status_nxt = ST_OK;
    if (in_action == ACT_INSERT) begin
      if (full) begin
        status_nxt = ST_FULL;
      end
    end else if (empty) begin
      status_nxt = ST_EMPTY;
    end
  end

  // Only the low KEY_WIDTH bits of the ready time are kept in the cells.
  generate
    if (KEY_WIDTH >= SPQ_FIELD_W) begin : g_key_wide
      assign new_time  = KEY_WIDTH'(in_ready_time);
      assign head_time = c_time[0][SPQ_FIELD_W-1:0];
    end else begin : g_key_narrow
      assign new_time  = in_ready_time[KEY_WIDTH-1:0];
      assign head_time = SPQ_FIELD_W'(c_time[0]);
    end
  endgenerate

  // The reported fill level is the count masked to the port width.
  generate
    if (CNT_W >= SPQ_FILL_W) begin : g_fill_wide
      assign fill_nxt = count_nxt[SPQ_FILL_W-1:0];
    end else begin : g_fill_narrow
      assign fill_nxt = SPQ_FILL_W'(count_nxt);
    end
  endgenerate

  // The chain. Cell 0 sees a left neighbor that is always ahead, so a new entry lands
  // there when it sorts first; the last cell shifts in don't-care data on a pop.
  generate
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
        assign l_ahead[i] = 1'b1;
        assign l_time[i]  = '0;
        assign l_id[i]    = '0;
        assign l_pay[i]   = '0;
      end else begin : g_mid
        assign l_ahead[i] = c_ahead[i-1];
        assign l_time[i]  = c_time[i-1];
        assign l_id[i]    = c_id[i-1];
        assign l_pay[i]   = c_pay[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
        assign r_time[i] = '0;
        assign r_id[i]   = '0;
        assign r_pay[i]  = '0;
      end else begin : g_inner
        assign r_time[i] = c_time[i+1];
        assign r_id[i]   = c_id[i+1];
        assign r_pay[i]  = c_pay[i+1];
      end

      spq_cell #(
        .KEY_WIDTH (KEY_WIDTH),
        .CNT_W     (CNT_W),
        .IDX       (i)
      ) u_cell (
        .clk        (clk),
        .op         (op),
        .count      (count_r),
        .new_time   (new_time),
        .new_id     (in_entry_id),
        .new_pay    (in_payload),
        .left_ahead (l_ahead[i]),
        .left_time  (l_time[i]),
        .left_id    (l_id[i]),
        .left_pay   (l_pay[i]),
        .right_time (r_time[i]),
        .right_id   (r_id[i]),
        .right_pay  (r_pay[i]),
        .ahead      (c_ahead[i]),
        .time_q     (c_time[i]),
        .id_q       (c_id[i]),
        .pay_q      (c_pay[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (acc) begin
        out_vld_r <= 1'b1;
      end else if (out_rdy) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Result payload; fields other than status and fill are zero unless a pop succeeded.
  always_ff @(posedge clk) begin
    if (acc) begin
      out_valid_r  <= op.pop;
      out_time_r   <= op.pop ? head_time : '0;
      out_id_r     <= op.pop ? c_id[0] : '0;
      out_pay_r    <= op.pop ? c_pay[0] : '0;
      out_status_r <= status_nxt;
      out_fill_r   <= fill_nxt;
    end
  end

  assign out_vld        = out_vld_r;
  assign out_valid      = out_valid_r;
  assign out_time       = out_time_r;
  assign out_id         = out_id_r;
  assign out_payload    = out_pay_r;
  assign out_status     = out_status_r;
  assign out_fill_level = out_fill_r;

  // The fill count never goes past the number of cells.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("fill count exceeds queue depth");

  // A pop on a non-empty queue returns an entry in the next result.
  a_pop_returns : assert property (@(posedge clk) disable iff (!rst_n)
    op.pop |=> (out_vld && out_valid && (out_status == ST_OK)))
    else $error("pop on non-empty queue did not return an entry");

  // An insert into a full queue is flagged and leaves the count alone.
  a_full_drop : assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_action == ACT_INSERT) && full) |=>
      ((count_r == $past(count_r)) && (out_status == ST_FULL) && !out_valid))
    else $error("insert into full queue was not dropped");

  // The two front cells stay in sorted order.
  a_head_sorted : assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |->
      ((c_time[0] < c_time[1]) || ((c_time[0] == c_time[1]) && (c_id[0] <= c_id[1]))))
    else $error("head entries out of order");

endmodule : sorted_priority_queue_unit

`default_nettype wire

/* test/sorted_priority_queue_unit_tb.sv */
// Testbench for sorted_priority_queue_unit: directed and random commands checked against a predictor.
`timescale 1ns / 1ps

module sorted_priority_queue_unit_tb;
  import spq_pkg::*;

  // The block runs at its default sizes, so the predictor uses the same ones.
  localparam int DEPTH = SPQ_DEPTH;
  localparam int FW = SPQ_FIELD_W;
  localparam logic [FW-1:0] KEY_MASK = FW'((64'd1 << SPQ_KEY_WIDTH) - 1);

  // Cycles with no beat on either channel before the run is declared hung.
  // The longest sender gap or receiver stall at 78 percent stays far below this.
  localparam int HANG_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int MAX_PRINTED = 20;

  typedef struct packed {
    logic [FW-1:0] rdy_time;
    logic [FW-1:0] id;
    logic [FW-1:0] pay;
  } held_entry_t;

  typedef struct packed {
    logic            valid;
    logic [FW-1:0]   rdy_time;
    logic [FW-1:0]   id;
    logic [FW-1:0]   pay;
    status_t         status;
    logic [SPQ_FILL_W-1:0] fill;
  } queue_result_t;

  // One command. When known is set, the row carries its result typed in by hand
  // and that replaces the predicted one.
  typedef struct {
    action_t       act;
    logic [FW-1:0] rdy_time;
    logic [FW-1:0] id;
    logic [FW-1:0] pay;
    bit            known;
    queue_result_t result;
  } queue_cmd_t;

  logic clk;
  logic rst_n;
  logic in_vld;
  logic in_rdy;
  logic in_action;
  logic [FW-1:0] in_ready_time;
  logic [FW-1:0] in_entry_id;
  logic [FW-1:0] in_payload;
  logic out_vld;
  logic out_rdy;
  logic out_valid;
  logic [FW-1:0] out_time;
  logic [FW-1:0] out_id;
  logic [FW-1:0] out_payload;
  logic [1:0] out_status;
  logic [SPQ_FILL_W-1:0] out_fill_level;

  sorted_priority_queue_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_vld         (in_vld),
    .in_rdy         (in_rdy),
    .in_action      (in_action),
    .in_ready_time  (in_ready_time),
    .in_entry_id    (in_entry_id),
    .in_payload     (in_payload),
    .out_vld        (out_vld),
    .out_rdy        (out_rdy),
    .out_valid      (out_valid),
    .out_time       (out_time),
    .out_id         (out_id),
    .out_payload    (out_payload),
    .out_status     (out_status),
    .out_fill_level (out_fill_level)
  );

  // Predictor state: the entries the queue should hold, head first.
  held_entry_t   held_entries[$];
  queue_result_t expected_results[$];
  queue_cmd_t    directed_cmds[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned error_count;
  int unsigned result_beats;
  int unsigned quiet_cycles;

  // What the run went through, printed in the summary.
  int unsigned n_inserted;
  int unsigned n_dropped;
  int unsigned n_popped;
  int unsigned n_empty_pops;
  int unsigned peak_fill;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Appends one command to the directed table.
  function automatic void add_row(action_t act, logic [FW-1:0] t, logic [FW-1:0] id,
                                  logic [FW-1:0] pay);
    queue_cmd_t c;
    c.act = act;
    c.rdy_time = t;
    c.id = id;
    c.pay = pay;
    c.known = 1'b0;
    c.result = '0;
    directed_cmds.push_back(c);
  endfunction

  // Types in the result of the last directed command.
  function automatic void pin_last(logic valid, logic [FW-1:0] t, logic [FW-1:0] id,
                                   logic [FW-1:0] pay, status_t st,
                                   logic [SPQ_FILL_W-1:0] fill);
    int last;
    last = directed_cmds.size() - 1;
    directed_cmds[last].known = 1'b1;
    directed_cmds[last].result = '{valid, t, id, pay, st, fill};
  endfunction

  // Works out the result of one accepted command and updates the held entries.
  // A new entry walks past every held entry with a smaller ready time, or the same
  // ready time and an id no larger, so equal keys leave in arrival order.
  function automatic queue_result_t predict_queue_result(queue_cmd_t c);
    queue_result_t r;
    held_entry_t e;
    int pos;
    r = '0;
    r.status = ST_OK;
    if (c.act == ACT_INSERT) begin
      if (held_entries.size() >= DEPTH) begin
        r.status = ST_FULL;
        n_dropped++;
      end else begin
        e.rdy_time = c.rdy_time & KEY_MASK;
        e.id = c.id;
        e.pay = c.pay;
        pos = 0;
        while (pos < held_entries.size() &&
               (held_entries[pos].rdy_time < e.rdy_time ||
                (held_entries[pos].rdy_time == e.rdy_time && held_entries[pos].id <= e.id)))
          pos++;
        held_entries.insert(pos, e);
        n_inserted++;
      end
    end else begin
      if (held_entries.size() == 0) begin
        r.status = ST_EMPTY;
        n_empty_pops++;
      end else begin
        e = held_entries.pop_front();
        r.valid = 1'b1;
        r.rdy_time = e.rdy_time;
        r.id = e.id;
        r.pay = e.pay;
        n_popped++;
      end
    end
    r.fill = SPQ_FILL_W'(held_entries.size());
    if (held_entries.size() > peak_fill)
      peak_fill = held_entries.size();
    return r;
  endfunction

  // Random command. Keys are drawn so that ties, extremes and wide spreads all occur.
  function automatic queue_cmd_t random_cmd(int unsigned pop_pct);
    queue_cmd_t c;
    int unsigned pick;
    c.act = ($urandom_range(0, 99) < pop_pct) ? ACT_POP : ACT_INSERT;
    pick = $urandom_range(0, 5);
    case (pick)
      0, 1: begin
        c.rdy_time = FW'($urandom_range(0, 3));
        c.id = FW'($urandom_range(0, 3));
      end
      4: begin
        c.rdy_time = $urandom_range(0, 1) ? '1 : '0;
        c.id = $urandom_range(0, 1) ? '1 : '0;
      end
      5: begin
        c.rdy_time = FW'($urandom_range(16'hFFF0, 16'hFFFF));
        c.id = FW'($urandom);
      end
      default: begin
        c.rdy_time = FW'($urandom);
        c.id = FW'($urandom);
      end
    endcase
    c.pay = FW'($urandom);
    c.known = 1'b0;
    c.result = '0;
    return c;
  endfunction

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(string what, logic [FW-1:0] got, logic [FW-1:0] want);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("%0t: result beat %0d: %s: got %h, expected %h", $realtime, result_beats,
               what, got, want);
  endtask

  // Presents one command after an optional gap and returns at the edge that accepts it.
  // The expectation is queued at that same edge.
  task automatic send_beat(queue_cmd_t c);
    queue_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_vld <= 1'b0;
      @(posedge clk);
    end
    in_vld <= 1'b1;
    in_action <= c.act;
    in_ready_time <= c.rdy_time;
    in_entry_id <= c.id;
    in_payload <= c.pay;
    do
      @(posedge clk);
    while (!in_rdy);
    predicted = predict_queue_result(c);
    if (c.known)
      predicted = c.result;
    expected_results.push_back(predicted);
  endtask

  // The receiver stalls at random with the rate of the current phase.
  always @(posedge clk) begin
    out_rdy <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Every result beat is checked, field by field, against the oldest expectation.
  always @(posedge clk) begin
    queue_result_t want;
    if (rst_n && out_vld && out_rdy) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", out_time, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_valid !== want.valid)
          report_mismatch("out_valid", FW'(out_valid), FW'(want.valid));
        if (out_time !== want.rdy_time)
          report_mismatch("out_time", out_time, want.rdy_time);
        if (out_id !== want.id)
          report_mismatch("out_id", out_id, want.id);
        if (out_payload !== want.pay)
          report_mismatch("out_payload", out_payload, want.pay);
        if (out_status !== want.status)
          report_mismatch("out_status", FW'(out_status), FW'(want.status));
        if (out_fill_level !== want.fill)
          report_mismatch("out_fill_level", FW'(out_fill_level), FW'(want.fill));
      end
      result_beats++;
    end
  end

  // Watchdog: a run in which no beat moves for too long has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_vld && in_rdy) || (out_vld && out_rdy)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $realtime, HANG_LIMIT);
        $display("sorted_priority_queue_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int unsigned pop_pct;
    int unsigned gap_tab[4];
    int unsigned stall_tab[4];
    int unsigned pop_tab[3];

    clk = 1'b0;
    rst_n <= 1'b0;
    in_vld <= 1'b0;
    in_action <= ACT_INSERT;
    in_ready_time <= '0;
    in_entry_id <= '0;
    in_payload <= '0;
    out_rdy <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    error_count = 0;
    result_beats = 0;
    quiet_cycles = 0;
    n_inserted = 0;
    n_dropped = 0;
    n_popped = 0;
    n_empty_pops = 0;
    peak_fill = 0;

    // Four idling phases: none, sender mostly idle, receiver mostly stalled, both light.
    gap_tab = '{0, 78, 0, 13};
    stall_tab = '{0, 0, 78, 13};
    pop_tab = '{25, 50, 75};

    // Directed table. A pop right after reset must find the queue empty.
    add_row(ACT_POP, 16'h1234, 16'h5678, 16'h9ABC);
    pin_last(1'b0, '0, '0, '0, ST_EMPTY, 5'd0);
    add_row(ACT_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    pin_last(1'b0, '0, '0, '0, ST_OK, 5'd1);
    add_row(ACT_INSERT, 16'h0000, 16'h0000, 16'h0000);
    pin_last(1'b0, '0, '0, '0, ST_OK, 5'd2);
    // Same key as the one before, so it has to line up behind it.
    add_row(ACT_INSERT, 16'h0000, 16'h0000, 16'h1234);
    add_row(ACT_INSERT, 16'h0000, 16'h0001, 16'hAAAA);
    add_row(ACT_INSERT, 16'h0001, 16'h0000, 16'h5555);
    add_row(ACT_POP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    pin_last(1'b1, 16'h0000, 16'h0000, 16'h0000, ST_OK, 5'd4);
    // Fill to the top with an all-ones key that must go behind the first and falling ready
    // times, which keep inserting near the head; one more all-ones key is then dropped as full.
    add_row(ACT_INSERT, 16'hFFFF, 16'hFFFF, 16'h0001);
    for (int k = 11; k > 0; k--)
      add_row(ACT_INSERT, FW'(k * 16'h0101), FW'(16 - k), ~FW'(k));
    add_row(ACT_INSERT, 16'hFFFF, 16'hFFFF, 16'h7777);
    pin_last(1'b0, '0, '0, '0, ST_FULL, 5'(DEPTH));
    add_row(ACT_POP, 16'h0000, 16'h0000, 16'h0000);
    pin_last(1'b1, 16'h0000, 16'h0000, 16'h1234, ST_OK, 5'(DEPTH - 1));
    add_row(ACT_POP, 16'hFFFF, 16'hFFFF, 16'hFFFF);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The directed rows go out in the first phase, with no idling on either side.
    foreach (directed_cmds[i])
      send_beat(directed_cmds[i]);

    // Random commands. The pop rate changes every few dozen beats so the queue
    // swings between empty and full and both error cases keep coming up.
    pop_pct = 50;
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = gap_tab[phase];
      recv_stall_pct = stall_tab[phase];
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 32 == 0)
          pop_pct = pop_tab[$urandom_range(0, 2)];
        send_beat(random_cmd(pop_pct));
      end
    end
    in_vld <= 1'b0;

    // Drain, then give a stray extra result time to show up.
    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d result beats: %0d entries inserted, %0d dropped on full,",
             result_beats, n_inserted, n_dropped);
    $display("%0d popped, %0d pops on empty; deepest fill %0d of %0d; %0d mismatches.",
             n_popped, n_empty_pops, peak_fill, DEPTH, error_count);
    if (error_count == 0) begin
      $display("sorted_priority_queue_unit regression: pass");
    end else begin
      $display("sorted_priority_queue_unit regression: fail");
    end
    $finish;
  end

endmodule
